FILE: rtl/hbp_pkg.sv
`default_nettype none
package hbp_pkg;

   localparam int BYTE_W       = 8;
   localparam int CODE_W       = 32;
   localparam int LEN_W        = 6;
   localparam int CNT_W        = 3;
   localparam int TREE_W       = 13;
   localparam int ADDR_W       = 8;
   localparam int TABLE_DEPTH  = 256;
   localparam int MAX_CODE_LEN = 32;
   localparam int CODE_CAP     = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;
   localparam int ACC_W        = BYTE_W + CODE_W;
   localparam int TOTAL_W      = 6;

   // request command codes
   localparam logic [1:0] CMD_LOAD   = 2'd0;
   localparam logic [1:0] CMD_ENCODE = 2'd1;
   localparam logic [1:0] CMD_FLUSH  = 2'd2;

   // result byte kinds
   localparam logic [1:0] KIND_DATA   = 2'd0;
   localparam logic [1:0] KIND_HDR_HI = 2'd1;
   localparam logic [1:0] KIND_HDR_LO = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ALIGN,
      ST_EMIT,
      ST_FLUSH_DATA,
      ST_HDR_HI,
      ST_HDR_LO
   } state_type;

   typedef enum logic [2:0] {
      EMIT_NONE,
      EMIT_ACC,
      EMIT_PENDING,
      EMIT_HDR_HI,
      EMIT_HDR_LO
   } emit_type;

   typedef struct packed {
      logic     mem_write;
      logic     mem_read;
      logic     align;
      emit_type emit;
      logic     commit_pending;
      logic     clear_pending;
   } ctrl_cmd_type;

   typedef struct packed {
      logic total_ge8;
      logic total_lt16;
      logic pending_nz;
      logic out_free;
   } dp_status_type;

endpackage
`default_nettype wire

FILE: rtl/hbp_ctrl.sv
`default_nettype none
module hbp_ctrl
   import hbp_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   input  wire logic [1:0]    req_command,
   output logic               req_ready,
   input  wire dp_status_type status,
   output ctrl_cmd_type       cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '{mem_write: 1'b0, mem_read: 1'b0, align: 1'b0, emit: EMIT_NONE,
                    commit_pending: 1'b0, clear_pending: 1'b0};
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               case (req_command)
                  CMD_LOAD: begin
                     cmd.mem_write = 1'b1;
                  end
                  CMD_ENCODE: begin
                     cmd.mem_read = 1'b1;
                     state_in     = ST_ALIGN;
                  end
                  CMD_FLUSH: begin
                     state_in = status.pending_nz ? ST_FLUSH_DATA : ST_HDR_HI;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_ALIGN: begin
            cmd.align = 1'b1;
            state_in  = ST_EMIT;
         end
         ST_EMIT: begin
            if (!status.total_ge8) begin
               cmd.commit_pending = 1'b1;
               state_in           = ST_IDLE;
            end else if (status.out_free) begin
               cmd.emit = EMIT_ACC;
            end
         end
         ST_FLUSH_DATA: begin
            if (status.out_free) begin
               cmd.emit = EMIT_PENDING;
               state_in = ST_HDR_HI;
            end
         end
         ST_HDR_HI: begin
            if (status.out_free) begin
               cmd.emit = EMIT_HDR_HI;
               state_in = ST_HDR_LO;
            end
         end
         ST_HDR_LO: begin
            if (status.out_free) begin
               cmd.emit          = EMIT_HDR_LO;
               cmd.clear_pending = 1'b1;
               state_in          = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule
`default_nettype wire

FILE: rtl/hbp_datapath.sv
`default_nettype none
module hbp_datapath
   import hbp_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire ctrl_cmd_type        cmd,
   output dp_status_type            status,
   input  wire logic [ADDR_W-1:0]   req_symbol,
   input  wire logic [CODE_W-1:0]   req_code_bits,
   input  wire logic [LEN_W-1:0]    req_code_length,
   input  wire logic                csr_wr_en,
   input  wire logic [TREE_W-1:0]   csr_wr_data,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic [BYTE_W-1:0]        rsp_out_byte,
   output logic [1:0]               rsp_byte_kind,
   output logic                     rsp_last
);

   localparam logic [LEN_W-1:0] LEN_CAP   = LEN_W'(CODE_CAP);
   localparam logic [LEN_W-1:0] LEN_FULL  = LEN_W'(CODE_W);

   // code table: code in the upper bits, length in the lower
   logic [CODE_W+LEN_W-1:0] table_mem [TABLE_DEPTH];
   logic [CODE_W+LEN_W-1:0] rd_data_ff;

   logic [TREE_W-1:0]  tree_size_ff;
   logic [BYTE_W-1:0]  pend_byte_ff;
   logic [CNT_W-1:0]   pend_count_ff;
   logic [ACC_W-1:0]   acc_ff;
   logic [TOTAL_W-1:0] total_ff;

   logic               rsp_valid_ff;
   logic [BYTE_W-1:0]  out_byte_ff;
   logic [1:0]         kind_ff;
   logic               last_ff;

   logic [LEN_W-1:0]   wr_len;
   logic [CODE_W-1:0]  rd_code;
   logic [LEN_W-1:0]   rd_len;
   logic [CODE_W-1:0]  code_lj;
   logic [ACC_W-1:0]   acc_in;
   logic [TOTAL_W-1:0] total_in;
   logic [CNT_W-1:0]   pad;
   logic               out_free;

   assign wr_len  = (req_code_length > LEN_CAP) ? LEN_CAP : req_code_length;
   assign rd_code = rd_data_ff[CODE_W+LEN_W-1:LEN_W];
   assign rd_len  = rd_data_ff[LEN_W-1:0];

   // left-justify the code, then slot it in behind the pending bits
   assign code_lj  = rd_code << (LEN_FULL - rd_len);
   assign acc_in   = {pend_byte_ff, {CODE_W{1'b0}}}
                   | ({code_lj, {BYTE_W{1'b0}}} >> pend_count_ff);
   assign total_in = TOTAL_W'(pend_count_ff) + TOTAL_W'(rd_len);

   assign pad      = CNT_W'(0) - pend_count_ff;
   assign out_free = !rsp_valid_ff || rsp_ready;

   assign status.total_ge8  = (total_ff >= TOTAL_W'(BYTE_W));
   assign status.total_lt16 = (total_ff < TOTAL_W'(2 * BYTE_W));
   assign status.pending_nz = (pend_count_ff != '0);
   assign status.out_free   = out_free;

   always_ff @(posedge clock) begin
      if (cmd.mem_write) begin
         table_mem[req_symbol] <= {req_code_bits, wr_len};
      end
      if (cmd.mem_read) begin
         rd_data_ff <= table_mem[req_symbol];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.align) begin
         acc_ff   <= acc_in;
         total_ff <= total_in;
      end else if (cmd.emit == EMIT_ACC) begin
         acc_ff   <= acc_ff << BYTE_W;
         total_ff <= total_ff - TOTAL_W'(BYTE_W);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tree_size_ff  <= '0;
         pend_byte_ff  <= '0;
         pend_count_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            tree_size_ff <= csr_wr_data;
         end
         if (cmd.commit_pending) begin
            pend_byte_ff  <= acc_ff[ACC_W-1 -: BYTE_W];
            pend_count_ff <= total_ff[CNT_W-1:0];
         end else if (cmd.clear_pending) begin
            pend_byte_ff  <= '0;
            pend_count_ff <= '0;
         end
         if (cmd.emit != EMIT_NONE) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      case (cmd.emit)
         EMIT_ACC: begin
            out_byte_ff <= acc_ff[ACC_W-1 -: BYTE_W];
            kind_ff     <= KIND_DATA;
            last_ff     <= status.total_lt16;
         end
         EMIT_PENDING: begin
            out_byte_ff <= pend_byte_ff;
            kind_ff     <= KIND_DATA;
            last_ff     <= 1'b0;
         end
         EMIT_HDR_HI: begin
            out_byte_ff <= {pad, tree_size_ff[TREE_W-1:BYTE_W]};
            kind_ff     <= KIND_HDR_HI;
            last_ff     <= 1'b0;
         end
         EMIT_HDR_LO: begin
            out_byte_ff <= tree_size_ff[BYTE_W-1:0];
            kind_ff     <= KIND_HDR_LO;
            last_ff     <= 1'b1;
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_byte  = out_byte_ff;
   assign rsp_byte_kind = kind_ff;
   assign rsp_last      = last_ff;

endmodule
`default_nettype wire

FILE: rtl/huffman_bit_packer.sv
// Load item: written to the code table when taken, ready again the next cycle.
// Encode item: table read, align, one byte a cycle while the output register is free, then commit;
//   the first byte passes the table read and accumulator registers; the single output register sets the pace.
// Flush item: 2 or 3 bytes, one a cycle when output is free, next item taken the cycle after the last header byte.
// Reset (synchronous, active high) clears state machine, pending byte, tree size and output valid;
//   the code table is not cleared and holds nothing until loaded.
`default_nettype none
module huffman_bit_packer
   import hbp_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   // request channel
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire logic [1:0]          req_command,
   input  wire logic [ADDR_W-1:0]   req_symbol,
   input  wire logic [CODE_W-1:0]   req_code_bits,
   input  wire logic [LEN_W-1:0]    req_code_length,
   // result channel
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic [BYTE_W-1:0]        rsp_out_byte,
   output logic [1:0]               rsp_byte_kind,
   output logic                     rsp_last,
   // tree size register
   input  wire logic                csr_wr_en,
   input  wire logic [TREE_W-1:0]   csr_wr_data
);

   ctrl_cmd_type  cmd;
   dp_status_type status;

   // sequencer: one item at a time, steps through lookup, byte emission and header
   hbp_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_command (req_command),
      .req_ready   (req_ready),
      .status      (status),
      .cmd         (cmd)
   );

   // table, 40-bit packing accumulator, pending byte and the output register
   hbp_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_symbol      (req_symbol),
      .req_code_bits   (req_code_bits),
      .req_code_length (req_code_length),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_byte_kind   (rsp_byte_kind),
      .rsp_last        (rsp_last)
   );

endmodule
`default_nettype wire
